[rtl/dqkr_pkg.sv]
// ---------------------------------------------------------------------------
// dqkr_pkg
// Shared types and codes for the deque with key removal unit.
// ---------------------------------------------------------------------------
package dqkr_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int REQ_W   = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_NEW = 3'd0,
    REQ_PUSH_OLD = 3'd1,
    REQ_POP_NEW  = 3'd2,
    REQ_POP_OLD  = 3'd3,
    REQ_COUNT    = 3'd4,
    REQ_REMOVE   = 3'd5,
    REQ_STATUS   = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               ok;
    logic               found;
    logic [VALUE_W-1:0] oldest_value;
    logic [VALUE_W-1:0] newest_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } rsp_t;

endpackage

[rtl/dqkr_if.sv]
// ---------------------------------------------------------------------------
// dqkr_if
// Request and response channel interfaces, valid/ready handshake.
// ---------------------------------------------------------------------------
interface dqkr_req_if;
  logic                               valid;
  logic                               ready;
  logic [dqkr_pkg::REQ_W-1:0]         req_type;
  logic signed [dqkr_pkg::VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface dqkr_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic                                found;
  logic signed [dqkr_pkg::VALUE_W-1:0] oldest_value;
  logic signed [dqkr_pkg::VALUE_W-1:0] newest_value;
  logic [dqkr_pkg::COUNT_W-1:0]        entry_count;
  logic                                is_empty;

  modport source (output valid, output ok, output found, output oldest_value,
                  output newest_value, output entry_count, output is_empty,
                  input ready);
  modport sink   (input valid, input ok, input found, input oldest_value,
                  input newest_value, input entry_count, input is_empty,
                  output ready);
endinterface

[rtl/dqkr_ram.sv]
// ---------------------------------------------------------------------------
// dqkr_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ---------------------------------------------------------------------------
module dqkr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/dqkr_rsp_reg.sv]
// ---------------------------------------------------------------------------
// dqkr_rsp_reg
// Output register stage; holds one response until its transfer completes.
// ---------------------------------------------------------------------------
module dqkr_rsp_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rsp_valid,
  input  dqkr_pkg::rsp_t rsp,
  output logic           rsp_load_ok,
  dqkr_rsp_if.source     out_ch
);

  logic           full_r;
  logic           full_nxt;
  dqkr_pkg::rsp_t data_r;

  assign rsp_load_ok = !full_r || out_ch.ready;

  always_comb begin
    full_nxt = full_r;
    if (rsp_valid && rsp_load_ok) begin
      full_nxt = 1'b1;
    end else if (out_ch.ready) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_load_ok) begin
      data_r <= rsp;
    end
  end

  assign out_ch.valid        = full_r;
  assign out_ch.ok           = data_r.ok;
  assign out_ch.found        = data_r.found;
  assign out_ch.oldest_value = data_r.oldest_value;
  assign out_ch.newest_value = data_r.newest_value;
  assign out_ch.entry_count  = data_r.entry_count;
  assign out_ch.is_empty     = data_r.is_empty;

endmodule

[rtl/dqkr_ctrl.sv]
// ---------------------------------------------------------------------------
// dqkr_ctrl
// Request sequencer: end pointers, end value shadows and the key walk that
// reads and compares entries in the RAM and, for remove, compacts them.
// ---------------------------------------------------------------------------
module dqkr_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  dqkr_req_if.sink                 in_ch,
  output logic                     rsp_valid,
  output dqkr_pkg::rsp_t           rsp,
  input  logic                     rsp_load_ok,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [DATA_WIDTH-1:0]    ram_wdata,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [DATA_WIDTH-1:0]    ram_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((AW > CW) ? AW : CW) + 1;
  localparam int XW = DATA_WIDTH + dqkr_pkg::VALUE_W;
  localparam int KW = CW + dqkr_pkg::COUNT_W;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dqkr_pkg::state_t state_r, state_nxt;
  dqkr_pkg::req_t   req_r, req_nxt;
  logic [AW-1:0]         oldest_idx_r, oldest_idx_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         rd_ofs_r, rd_ofs_nxt;
  logic [CW-1:0]         wr_ofs_r, wr_ofs_nxt;
  logic                  dvld_r, dvld_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [DATA_WIDTH-1:0] oldest_val_r, oldest_val_nxt;
  logic [DATA_WIDTH-1:0] newest_val_r, newest_val_nxt;
  logic                  ok_r, ok_nxt;
  logic                  found_r, found_nxt;

  dqkr_pkg::req_t        in_req;
  logic [XW-1:0]         din_ext;
  logic [DATA_WIDTH-1:0] din;
  logic                  is_empty;
  logic                  is_full;
  logic [AW-1:0]         dec_idx;
  logic                  issuing;
  logic                  hit;
  logic signed [XW-1:0]  oldest_ext;
  logic signed [XW-1:0]  newest_ext;
  logic [KW-1:0]         count_ext;

  assign in_req   = dqkr_pkg::req_t'(in_ch.req_type);
  assign din_ext  = XW'($unsigned(in_ch.value));
  assign din      = din_ext[DATA_WIDTH-1:0];
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));
  assign dec_idx  = (oldest_idx_r == '0) ? AW'(DEPTH - 1) : oldest_idx_r - AW'(1);
  assign issuing  = (rd_ofs_r != count_r);
  assign hit      = (ram_rdata == key_r);

  assign in_ch.ready = (state_r == dqkr_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dqkr_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_req)
            dqkr_pkg::REQ_POP_NEW,
            dqkr_pkg::REQ_POP_OLD: begin
              state_nxt = (count_r > CW'(1)) ? dqkr_pkg::ST_LOAD : dqkr_pkg::ST_DONE;
            end
            dqkr_pkg::REQ_COUNT,
            dqkr_pkg::REQ_REMOVE: begin
              state_nxt = is_empty ? dqkr_pkg::ST_DONE : dqkr_pkg::ST_WALK;
            end
            default: begin
              state_nxt = dqkr_pkg::ST_DONE;
            end
          endcase
        end
      end
      dqkr_pkg::ST_LOAD: begin
        state_nxt = dqkr_pkg::ST_DONE;
      end
      dqkr_pkg::ST_WALK: begin
        if (!issuing) begin
          state_nxt = dqkr_pkg::ST_DONE;
        end
      end
      dqkr_pkg::ST_DONE: begin
        if (rsp_load_ok) begin
          state_nxt = dqkr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dqkr_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and RAM control
  always_comb begin
    req_nxt        = req_r;
    oldest_idx_nxt = oldest_idx_r;
    count_nxt      = count_r;
    rd_ofs_nxt     = rd_ofs_r;
    wr_ofs_nxt     = wr_ofs_r;
    dvld_nxt       = 1'b0;
    key_nxt        = key_r;
    oldest_val_nxt = oldest_val_r;
    newest_val_nxt = newest_val_r;
    ok_nxt         = ok_r;
    found_nxt      = found_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = din;
    ram_raddr      = '0;
    rsp_valid      = 1'b0;
    case (state_r)
      dqkr_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt    = in_req;
          key_nxt    = din;
          ok_nxt     = 1'b1;
          found_nxt  = 1'b0;
          rd_ofs_nxt = '0;
          wr_ofs_nxt = '0;
          case (in_req)
            dqkr_pkg::REQ_PUSH_NEW: begin
              if (is_full) begin
                ok_nxt = 1'b0;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = slot_of(oldest_idx_r, count_r);
                count_nxt      = count_r + CW'(1);
                newest_val_nxt = din;
                if (is_empty) begin
                  oldest_val_nxt = din;
                end
              end
            end
            dqkr_pkg::REQ_PUSH_OLD: begin
              if (is_full) begin
                ok_nxt = 1'b0;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = dec_idx;
                oldest_idx_nxt = dec_idx;
                count_nxt      = count_r + CW'(1);
                oldest_val_nxt = din;
                if (is_empty) begin
                  newest_val_nxt = din;
                end
              end
            end
            dqkr_pkg::REQ_POP_NEW: begin
              if (is_empty) begin
                ok_nxt = 1'b0;
              end else begin
                count_nxt = count_r - CW'(1);
                ram_raddr = slot_of(oldest_idx_r, count_r - CW'(2));
              end
            end
            dqkr_pkg::REQ_POP_OLD: begin
              if (is_empty) begin
                ok_nxt = 1'b0;
              end else begin
                count_nxt      = count_r - CW'(1);
                oldest_idx_nxt = slot_of(oldest_idx_r, CW'(1));
                ram_raddr      = slot_of(oldest_idx_r, CW'(1));
              end
            end
            dqkr_pkg::REQ_COUNT,
            dqkr_pkg::REQ_REMOVE,
            dqkr_pkg::REQ_STATUS: begin
              ok_nxt = 1'b1;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      dqkr_pkg::ST_LOAD: begin
        if (req_r == dqkr_pkg::REQ_POP_NEW) begin
          newest_val_nxt = ram_rdata;
        end else begin
          oldest_val_nxt = ram_rdata;
        end
      end
      dqkr_pkg::ST_WALK: begin
        ram_raddr  = slot_of(oldest_idx_r, rd_ofs_r);
        rd_ofs_nxt = rd_ofs_r + CW'(issuing);
        dvld_nxt   = issuing;
        if (dvld_r) begin
          if (req_r == dqkr_pkg::REQ_COUNT) begin
            if (hit) begin
              found_nxt = 1'b1;
            end
          end else if (!hit) begin
            // keep entry: compact toward the oldest end
            ram_we         = 1'b1;
            ram_waddr      = slot_of(oldest_idx_r, wr_ofs_r);
            ram_wdata      = ram_rdata;
            wr_ofs_nxt     = wr_ofs_r + CW'(1);
            newest_val_nxt = ram_rdata;
            if (wr_ofs_r == '0) begin
              oldest_val_nxt = ram_rdata;
            end
          end
        end
        if (!issuing && req_r == dqkr_pkg::REQ_REMOVE) begin
          count_nxt = wr_ofs_nxt;
        end
      end
      dqkr_pkg::ST_DONE: begin
        rsp_valid = 1'b1;
      end
      default: begin
        rsp_valid = 1'b0;
      end
    endcase
  end

  assign oldest_ext = XW'($signed(oldest_val_r));
  assign newest_ext = XW'($signed(newest_val_r));
  assign count_ext  = KW'(count_r);

  always_comb begin
    rsp.ok          = ok_r;
    rsp.found       = found_r;
    rsp.entry_count = count_ext[dqkr_pkg::COUNT_W-1:0];
    rsp.is_empty    = is_empty;
    if (is_empty) begin
      rsp.oldest_value = '0;
      rsp.newest_value = '0;
    end else begin
      rsp.oldest_value = oldest_ext[dqkr_pkg::VALUE_W-1:0];
      rsp.newest_value = newest_ext[dqkr_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dqkr_pkg::ST_IDLE;
      oldest_idx_r <= '0;
      count_r      <= '0;
      dvld_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      oldest_idx_r <= oldest_idx_nxt;
      count_r      <= count_nxt;
      dvld_r       <= dvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    rd_ofs_r     <= rd_ofs_nxt;
    wr_ofs_r     <= wr_ofs_nxt;
    key_r        <= key_nxt;
    oldest_val_r <= oldest_val_nxt;
    newest_val_r <= newest_val_nxt;
    ok_r         <= ok_nxt;
    found_r      <= found_nxt;
  end

endmodule

[rtl/deque_with_key_removal_unit.sv]
// ---------------------------------------------------------------------------
// deque_with_key_removal_unit
// Bounded double-ended queue of signed words with key search and removal.
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+-----------------------------------------
//   in_ch    | in  | valid/ready | req_type, value
//   out_ch   | out | valid/ready | ok, found, oldest_value, newest_value,
//            |     |             | entry_count, is_empty
//
// One request at a time. Push, status and failed requests go straight to
// the result. Pops do one RAM read for the new end value, unless at most
// one entry is held. Count key and remove key do one RAM read per entry,
// none on an empty queue.
// Synchronous reset empties the queue at once; no clearing pass.
// A stalled out_ch holds one result in the output register; the next
// request is still taken and waits at completion for that register.
// ---------------------------------------------------------------------------
module deque_with_key_removal_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  dqkr_req_if.sink   in_ch,
  dqkr_rsp_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);

  logic                  rsp_valid;
  logic                  rsp_load_ok;
  dqkr_pkg::rsp_t        rsp;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  dqkr_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .rsp_valid   (rsp_valid),
    .rsp         (rsp),
    .rsp_load_ok (rsp_load_ok),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  dqkr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  dqkr_rsp_reg u_rsp_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp_valid),
    .rsp         (rsp),
    .rsp_load_ok (rsp_load_ok),
    .out_ch      (out_ch)
  );

endmodule

[tb/deque_with_key_removal_unit_tb.sv]
// ---------------------------------------------------------------------------
// deque_with_key_removal_unit_tb
// Self-checking bench for the deque with key removal unit. A behavioral
// deque tracks every accepted request and predicts the status it returns;
// each transfer on the result channel is compared field by field. Directed
// requests cover empty, full, extreme values and key search/removal, then
// biased random traffic grows and drains the queue with random stalls.
// ---------------------------------------------------------------------------
module deque_with_key_removal_unit_tb;

  localparam int          VW           = dqkr_pkg::VALUE_W;
  localparam int          SLOTS        = 16;
  localparam int          RANDOM_ITEMS = 1400;
  localparam int          PHASE_LEN    = 64;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [2:0]  REQ_UNKNOWN  = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  dqkr_req_if in_ch ();
  dqkr_rsp_if out_ch ();

  deque_with_key_removal_unit #(
    .DEPTH     (SLOTS),
    .DATA_WIDTH(VW)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioral deque
  logic [VW-1:0]     deque_slots [SLOTS];
  logic [3:0]        oldest_pos;
  int                held_cnt;
  dqkr_pkg::rsp_t    pending_status [$];

  int err_count;
  int cycle_count;
  int req_count;
  int full_rejects;
  int empty_rejects;
  int key_hits;
  int keys_removed;
  bit no_idle;
  bit grow_bias;

  function automatic logic [3:0] slot_of(int offset);
    return oldest_pos + offset[3:0];
  endfunction

  function automatic dqkr_pkg::rsp_t apply_request(logic [2:0] code, logic [VW-1:0] data);
    dqkr_pkg::rsp_t r;
    int   wr;
    logic [VW-1:0] e;
    r = '0;
    r.ok = 1'b1;
    case (code)
      dqkr_pkg::REQ_PUSH_NEW: begin
        if (held_cnt >= SLOTS) begin
          r.ok = 1'b0;
          full_rejects++;
        end else begin
          deque_slots[slot_of(held_cnt)] = data;
          held_cnt++;
        end
      end
      dqkr_pkg::REQ_PUSH_OLD: begin
        if (held_cnt >= SLOTS) begin
          r.ok = 1'b0;
          full_rejects++;
        end else begin
          oldest_pos = oldest_pos - 4'd1;
          deque_slots[oldest_pos] = data;
          held_cnt++;
        end
      end
      dqkr_pkg::REQ_POP_NEW: begin
        if (held_cnt == 0) begin
          r.ok = 1'b0;
          empty_rejects++;
        end else begin
          held_cnt--;
        end
      end
      dqkr_pkg::REQ_POP_OLD: begin
        if (held_cnt == 0) begin
          r.ok = 1'b0;
          empty_rejects++;
        end else begin
          oldest_pos = oldest_pos + 4'd1;
          held_cnt--;
        end
      end
      dqkr_pkg::REQ_COUNT: begin
        for (int i = 0; i < held_cnt; i++)
          if (deque_slots[slot_of(i)] == data) r.found = 1'b1;
        if (r.found) key_hits++;
      end
      dqkr_pkg::REQ_REMOVE: begin
        wr = 0;
        for (int rd = 0; rd < held_cnt; rd++) begin
          e = deque_slots[slot_of(rd)];
          if (e != data) begin
            deque_slots[slot_of(wr)] = e;
            wr++;
          end
        end
        keys_removed += held_cnt - wr;
        held_cnt = wr;
      end
      dqkr_pkg::REQ_STATUS: ;
      default: r.ok = 1'b0;
    endcase
    if (held_cnt != 0) begin
      r.oldest_value = deque_slots[slot_of(0)];
      r.newest_value = deque_slots[slot_of(held_cnt - 1)];
    end
    r.entry_count = held_cnt[dqkr_pkg::COUNT_W-1:0];
    r.is_empty    = (held_cnt == 0);
    return r;
  endfunction

  // mostly short gaps, a few long ones; none while no_idle is set
  function automatic int pick_idle();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(logic [2:0] code, logic [VW-1:0] data);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= code;
    in_ch.value    <= data;
    do @(posedge clk); while (!in_ch.ready);
    pending_status.push_back(apply_request(code, data));
    req_count++;
    gap = pick_idle();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random stalls on ready
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_idle();
      end
    end
  end

  function automatic void check_field(string fname, logic [VW-1:0] want,
                                      logic [VW-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  dqkr_pkg::rsp_t checked_want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        err_count++;
        $display("%0t: result transfer with nothing expected, actual count %0d",
                 $time, out_ch.entry_count);
      end else begin
        checked_want = pending_status[0];
        pending_status.delete(0);
        check_field("ok", VW'(checked_want.ok), VW'(out_ch.ok));
        check_field("found", VW'(checked_want.found), VW'(out_ch.found));
        check_field("oldest_value", checked_want.oldest_value, out_ch.oldest_value);
        check_field("newest_value", checked_want.newest_value, out_ch.newest_value);
        check_field("entry_count", VW'(checked_want.entry_count), VW'(out_ch.entry_count));
        check_field("is_empty", VW'(checked_want.is_empty), VW'(out_ch.is_empty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_status.size());
      $display("FAIL deque_with_key_removal_unit");
      $finish;
    end
  end

  task automatic test_empty_requests();
    send_request(dqkr_pkg::REQ_POP_NEW, 32'h0);
    send_request(dqkr_pkg::REQ_POP_OLD, 32'h0);
    send_request(dqkr_pkg::REQ_COUNT, 32'h8000_0000);
    send_request(dqkr_pkg::REQ_REMOVE, 32'h7FFF_FFFF);
    send_request(REQ_UNKNOWN, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_and_overflow();
    logic [VW-1:0] fill [16] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0005, 32'h0000_0005, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h0000_0005, 32'h0000_0001, 32'h0000_0005, 32'h1234_5678,
      32'h0000_0005, 32'hFFFF_FFFE, 32'h8000_0001, 32'h0000_0005};
    for (int i = 0; i < 16; i++)
      send_request((i % 2) ? dqkr_pkg::REQ_PUSH_OLD : dqkr_pkg::REQ_PUSH_NEW, fill[i]);
    send_request(dqkr_pkg::REQ_PUSH_NEW, 32'h0000_0042);
    send_request(dqkr_pkg::REQ_PUSH_OLD, 32'h0000_0043);
  endtask

  task automatic test_key_requests();
    send_request(dqkr_pkg::REQ_COUNT, 32'h0000_0005);
    send_request(dqkr_pkg::REQ_COUNT, 32'h0BAD_0BAD);
    send_request(dqkr_pkg::REQ_REMOVE, 32'h0000_0005);
    send_request(dqkr_pkg::REQ_REMOVE, 32'h0BAD_0BAD);
    send_request(dqkr_pkg::REQ_STATUS, 32'h0);
  endtask

  task automatic test_end_pops();
    send_request(dqkr_pkg::REQ_POP_NEW, 32'h0);
    send_request(dqkr_pkg::REQ_POP_OLD, 32'h0);
  endtask

  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] key_pool [8] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h0000_0005, 32'h55AA_55AA, 32'hC3C3_0F0F};
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)  return REQ_UNKNOWN;
    if (r < 8)  return dqkr_pkg::REQ_STATUS;
    if (r < 20) return dqkr_pkg::REQ_COUNT;
    if (r < 27) return dqkr_pkg::REQ_REMOVE;
    if (grow_bias) begin
      if (r < 47) return 3'(dqkr_pkg::REQ_POP_NEW + $urandom_range(0, 1));
      return 3'(dqkr_pkg::REQ_PUSH_NEW + $urandom_range(0, 1));
    end
    if (r < 77) return 3'(dqkr_pkg::REQ_POP_NEW + $urandom_range(0, 1));
    return 3'(dqkr_pkg::REQ_PUSH_NEW + $urandom_range(0, 1));
  endfunction

  task automatic test_random_traffic(int n);
    for (int i = 0; i < n; i++) begin
      if (i % PHASE_LEN == 0) begin
        grow_bias = ~grow_bias;
        no_idle   = ($urandom_range(0, 3) == 0);
      end
      send_request(pick_request(), pick_value());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= dqkr_pkg::REQ_STATUS;
    in_ch.value    <= '0;
    err_count     = 0;
    cycle_count   = 0;
    req_count     = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    key_hits      = 0;
    keys_removed  = 0;
    no_idle       = 1'b0;
    grow_bias     = 1'b0;
    oldest_pos    = '0;
    held_cnt      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_requests();
    test_fill_and_overflow();
    test_key_requests();
    test_end_pops();
    test_random_traffic(RANDOM_ITEMS);

    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests in %0d cycles: %0d full-queue pushes, %0d empty pops,",
             req_count, cycle_count, full_rejects, empty_rejects);
    $display("%0d key hits, %0d entries removed by key, %0d mismatches",
             key_hits, keys_removed, err_count);
    if (err_count == 0) begin
      $display("PASS deque_with_key_removal_unit");
    end else begin
      $display("FAIL deque_with_key_removal_unit");
    end
    $finish;
  end

endmodule
